@@ src/ttq_pkg.sv @@
`default_nettype none
package ttq_pkg;

    localparam int SLOT_COUNT_DEF = 16;
    localparam int MAX_RESULTS    = 16;

    typedef enum logic [1:0] {
        MODE_TICK     = 2'd0,
        MODE_ONESHOT  = 2'd1,
        MODE_PERIODIC = 2'd2,
        MODE_REMOVE   = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        ST_SCHEDULED = 3'd0,
        ST_FULL      = 3'd1,
        ST_REMOVED   = 3'd2,
        ST_UNLISTED  = 3'd3,
        ST_BAD       = 3'd4,
        ST_FIRED     = 3'd5,
        ST_NONE      = 3'd6
    } t_status;

    typedef enum logic {
        CFG_MIN_DELAY = 1'b0,
        CFG_LOOKAHEAD = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] delay_ticks;
        logic [15:0] task_tag;
        logic [15:0] task_argument;
        logic [3:0]  slot_handle;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  slot;
        logic [15:0] fired_tag;
        logic [15:0] fired_argument;
        logic [31:0] due_time;
        logic        last;
    } t_out_item;

    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [31:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [31:0] quotient;
    } t_div_rsp;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DECODE,
        S_SCHED_DIV,
        S_SCHED_WR,
        S_INS_START,
        S_INS_RD,
        S_INS_CMP,
        S_INS_LINK,
        S_REM_RD,
        S_REM_CMP,
        S_REM_DONE,
        S_TICK_RD,
        S_TICK_CHK,
        S_TICK_DIV,
        S_TICK_NEXT,
        S_OUT
    } t_state;

endpackage
`default_nettype wire

@@ src/ttq_ram.sv @@
`default_nettype none
module ttq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire  [$clog2(DEPTH)-1:0] i_waddr,
    input  wire  [WIDTH-1:0]         i_wdata,
    input  wire  [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

@@ src/ttq_div.sv @@
`default_nettype none
module ttq_div (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  ttq_pkg::t_div_req   i_req,
    output ttq_pkg::t_div_rsp   o_rsp
);
    logic [31:0] r_quo;
    logic [31:0] r_rem;
    logic [31:0] r_den;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [32:0] w_trial;

    assign w_trial = {r_rem, r_quo[31]} - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd32;
                r_quo  <= i_req.dividend;
                r_rem  <= '0;
                r_den  <= i_req.divisor;
            end else if (r_busy) begin
                if (!w_trial[32]) begin
                    r_rem <= w_trial[31:0];
                    r_quo <= {r_quo[30:0], 1'b1};
                end else begin
                    r_rem <= {r_rem[30:0], r_quo[31]};
                    r_quo <= {r_quo[30:0], 1'b0};
                end
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.busy     = r_busy;
    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;
endmodule
`default_nettype wire

@@ src/timed_task_queue.sv @@
// Channel  Direction  Handshake                 Payload
// in       input      i_in_valid / o_in_ready   ttq_pkg::t_in_item
// out      output     o_out_valid / i_out_ready ttq_pkg::t_out_item
// cfg      input      i_cfg_valid / o_cfg_ready index, data
//
// One item at a time. A schedule and a remove each walk the list entry by
// entry; a periodic schedule or re-arm also waits for the serial divider. A
// tick fires its tasks one by one and, for each periodic one, divides and
// inserts it again.
// Reset clears now, head, count and used bits. A stalled output
// holds the sequencer; results leave through one output register.
`default_nettype none
module timed_task_queue #(
    parameter int SLOT_COUNT = ttq_pkg::SLOT_COUNT_DEF
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    input  ttq_pkg::t_in_item   i_in_item,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output ttq_pkg::t_out_item  o_out_item,
    input  wire                 i_cfg_valid,
    output logic                o_cfg_ready,
    input  wire                 i_cfg_index,
    input  wire  [15:0]         i_cfg_data
);
    localparam int SW = $clog2(SLOT_COUNT);
    localparam int LW = SW + 1;
    localparam logic [LW-1:0] NIL = LW'(SLOT_COUNT);
    localparam int MW = ttq_pkg::MAX_RESULTS;

    ttq_pkg::t_state r_state, n_state;
    ttq_pkg::t_in_item r_in;
    logic [31:0] r_now;
    logic [15:0] r_min_delay;
    logic [7:0]  r_lookahead;
    logic [LW-1:0] r_head;
    logic [LW-1:0] r_count;
    logic [SLOT_COUNT-1:0] r_used;
    logic [SLOT_COUNT-1:0] r_fired;
    logic [SW-1:0] r_slot;
    logic [31:0] r_due;
    logic [31:0] r_per;
    logic [LW-1:0] r_prev;
    logic [LW-1:0] r_cur;
    logic [4:0] r_nres;
    logic r_ret_tick;
    logic r_out_valid;
    ttq_pkg::t_out_item r_out;
    ttq_pkg::t_out_item r_obuf;
    logic out_load;

    logic due_we, per_we, tag_we, arg_we, lnk_we;
    logic [SW-1:0] due_wa, lnk_wa, rd_a;
    logic [31:0] due_wd, per_wd;
    logic [LW-1:0] lnk_wd;
    logic [31:0] due_rd, per_rd;
    logic [15:0] tag_rd, arg_rd;
    logic [LW-1:0] lnk_rd;

    ttq_pkg::t_div_req div_req;
    ttq_pkg::t_div_rsp div_rsp;

    ttq_ram #(.WIDTH(32), .DEPTH(SLOT_COUNT)) u_due (
        .i_clk(i_clk), .i_we(due_we), .i_waddr(due_wa), .i_wdata(due_wd),
        .i_raddr(rd_a), .o_rdata(due_rd));
    ttq_ram #(.WIDTH(32), .DEPTH(SLOT_COUNT)) u_per (
        .i_clk(i_clk), .i_we(per_we), .i_waddr(r_slot), .i_wdata(per_wd),
        .i_raddr(rd_a), .o_rdata(per_rd));
    ttq_ram #(.WIDTH(16), .DEPTH(SLOT_COUNT)) u_tag (
        .i_clk(i_clk), .i_we(tag_we), .i_waddr(r_slot), .i_wdata(r_in.task_tag),
        .i_raddr(rd_a), .o_rdata(tag_rd));
    ttq_ram #(.WIDTH(16), .DEPTH(SLOT_COUNT)) u_arg (
        .i_clk(i_clk), .i_we(arg_we), .i_waddr(r_slot),
        .i_wdata(r_in.task_argument), .i_raddr(rd_a), .o_rdata(arg_rd));
    ttq_ram #(.WIDTH(LW), .DEPTH(SLOT_COUNT)) u_lnk (
        .i_clk(i_clk), .i_we(lnk_we), .i_waddr(lnk_wa), .i_wdata(lnk_wd),
        .i_raddr(rd_a), .o_rdata(lnk_rd));

    ttq_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(div_req), .o_rsp(div_rsp));

    logic [31:0] eff_delay;
    logic [SW-1:0] free_slot;
    logic free_found;
    logic [31:0] window;
    logic [31:0] quo_inc;
    logic [31:0] prod;

    always_comb begin
        eff_delay = (r_in.delay_ticks < {16'd0, r_min_delay}) ?
                    {16'd0, r_min_delay} : r_in.delay_ticks;
        free_found = 1'b0;
        free_slot  = '0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
            if (!r_used[i]) begin
                free_found = 1'b1;
                free_slot  = SW'(i);
            end
        end
        window  = r_now + {24'd0, r_lookahead};
        quo_inc = div_rsp.quotient + 32'd1;
        prod    = quo_inc * r_per;
    end

    logic [31:0] n_now, n_due, n_per;
    logic [LW-1:0] n_head, n_count, n_prev, n_cur;
    logic [SLOT_COUNT-1:0] n_used, n_fired;
    logic [SW-1:0] n_slot;
    logic [4:0] n_nres;
    logic n_ret_tick, n_out_valid;
    ttq_pkg::t_out_item n_out;

    always_comb begin
        n_state = r_state; n_now = r_now; n_due = r_due; n_per = r_per;
        n_head = r_head; n_count = r_count; n_prev = r_prev; n_cur = r_cur;
        n_used = r_used; n_fired = r_fired; n_slot = r_slot; n_nres = r_nres;
        n_ret_tick = r_ret_tick; n_out = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        out_load = 1'b0;
        due_we = 1'b0; per_we = 1'b0; tag_we = 1'b0; arg_we = 1'b0; lnk_we = 1'b0;
        due_wa = r_slot; due_wd = r_due; per_wd = r_per;
        lnk_wa = r_slot; lnk_wd = NIL; rd_a = r_cur[SW-1:0];
        div_req = '0;
        o_in_ready = (r_state == ttq_pkg::S_IDLE);
        case (r_state)
            ttq_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = ttq_pkg::S_DECODE;
                end
            end
            ttq_pkg::S_DECODE: begin
                n_out = '0;
                case (ttq_pkg::t_mode'(r_in.mode))
                    ttq_pkg::MODE_TICK: begin
                        n_now = r_now + 32'd1;
                        n_fired = '0; n_nres = '0;
                        n_cur = r_head;
                        n_state = ttq_pkg::S_TICK_RD;
                    end
                    ttq_pkg::MODE_REMOVE: begin
                        n_out.slot = r_in.slot_handle;
                        n_out.last = 1'b1;
                        if (32'(r_in.slot_handle) >= 32'(SLOT_COUNT)) begin
                            n_out.status = ttq_pkg::ST_BAD;
                            n_state = ttq_pkg::S_OUT;
                        end else if (!r_used[r_in.slot_handle[SW-1:0]]) begin
                            n_out.status = ttq_pkg::ST_UNLISTED;
                            n_state = ttq_pkg::S_OUT;
                        end else begin
                            n_slot = r_in.slot_handle[SW-1:0];
                            n_out.status = ttq_pkg::ST_REMOVED;
                            n_prev = NIL; n_cur = r_head;
                            n_state = ttq_pkg::S_REM_RD;
                        end
                    end
                    default: begin
                        n_out.last = 1'b1;
                        n_ret_tick = 1'b0;
                        if (r_count >= LW'(SLOT_COUNT) || !free_found) begin
                            n_out.status = ttq_pkg::ST_FULL;
                            n_state = ttq_pkg::S_OUT;
                        end else begin
                            n_slot = free_slot;
                            n_out.status = ttq_pkg::ST_SCHEDULED;
                            n_out.slot = 4'(free_slot);
                            if (r_in.mode == ttq_pkg::MODE_ONESHOT) begin
                                n_due = r_now + eff_delay; n_per = '0;
                                n_state = ttq_pkg::S_SCHED_WR;
                            end else begin
                                n_per = (eff_delay == 32'd0) ? 32'd1 : eff_delay;
                                div_req.start = 1'b1;
                                div_req.dividend = r_now;
                                div_req.divisor = n_per;
                                n_state = ttq_pkg::S_SCHED_DIV;
                            end
                        end
                    end
                endcase
            end
            ttq_pkg::S_SCHED_DIV: begin
                if (div_rsp.done) begin
                    n_due = prod;
                    n_state = ttq_pkg::S_SCHED_WR;
                end
            end
            ttq_pkg::S_SCHED_WR: begin
                per_we = 1'b1; tag_we = 1'b1; arg_we = 1'b1;
                n_used[r_slot] = 1'b1;
                n_out.due_time = r_due;
                n_state = ttq_pkg::S_INS_START;
            end
            ttq_pkg::S_INS_START: begin
                due_we = 1'b1;
                n_prev = NIL; n_cur = r_head;
                n_state = ttq_pkg::S_INS_RD;
            end
            ttq_pkg::S_INS_RD: begin
                if (r_cur == NIL) begin
                    n_state = ttq_pkg::S_INS_LINK;
                end else begin
                    n_state = ttq_pkg::S_INS_CMP;
                end
            end
            ttq_pkg::S_INS_CMP: begin
                if ((r_prev == NIL) ? (r_due <= due_rd) : (r_due <= due_rd)) begin
                    n_state = ttq_pkg::S_INS_LINK;
                end else begin
                    n_prev = r_cur; n_cur = lnk_rd;
                    n_state = ttq_pkg::S_INS_RD;
                end
            end
            ttq_pkg::S_INS_LINK: begin
                lnk_we = 1'b1; lnk_wa = r_slot; lnk_wd = r_cur;
                n_count = r_count + LW'(1);
                if (r_prev == NIL) begin
                    n_head = {1'b0, r_slot};
                    n_state = r_ret_tick ? ttq_pkg::S_TICK_NEXT : ttq_pkg::S_OUT;
                end else begin
                    n_state = ttq_pkg::S_REM_DONE;
                end
            end
            ttq_pkg::S_REM_DONE: begin
                lnk_we = 1'b1;
                lnk_wa = r_prev[SW-1:0];
                lnk_wd = r_ret_tick || r_in.mode != ttq_pkg::MODE_REMOVE ?
                         {1'b0, r_slot} : r_cur;
                n_state = r_ret_tick ? ttq_pkg::S_TICK_NEXT : ttq_pkg::S_OUT;
            end
            ttq_pkg::S_REM_RD: begin
                if (r_cur == NIL) begin
                    n_used[r_slot] = 1'b0;
                    n_state = ttq_pkg::S_OUT;
                end else begin
                    n_state = ttq_pkg::S_REM_CMP;
                end
            end
            ttq_pkg::S_REM_CMP: begin
                if (r_cur == {1'b0, r_slot}) begin
                    n_out.due_time = due_rd;
                    n_used[r_slot] = 1'b0;
                    n_count = r_count - LW'(1);
                    if (r_prev == NIL) begin
                        n_head = lnk_rd;
                        n_state = ttq_pkg::S_OUT;
                    end else begin
                        n_cur = lnk_rd;
                        n_state = ttq_pkg::S_REM_DONE;
                    end
                end else begin
                    n_prev = r_cur; n_cur = lnk_rd;
                    n_state = ttq_pkg::S_REM_RD;
                end
            end
            ttq_pkg::S_TICK_RD: begin
                if (r_cur == NIL || r_nres == 5'(MW) || r_fired[r_cur[SW-1:0]]) begin
                    if (r_nres == '0) begin
                        n_out = '0;
                        n_out.status = ttq_pkg::ST_NONE;
                        n_out.due_time = r_now;
                        n_out.last = 1'b1;
                        n_state = ttq_pkg::S_OUT;
                    end else begin
                        n_out.last = 1'b1;
                        n_state = ttq_pkg::S_OUT;
                    end
                end else begin
                    n_state = ttq_pkg::S_TICK_CHK;
                end
            end
            ttq_pkg::S_TICK_CHK: begin
                if (due_rd > window) begin
                    n_out.last = 1'b1;
                    n_state = (r_nres == '0) ? ttq_pkg::S_TICK_RD : ttq_pkg::S_OUT;
                    if (r_nres == '0) begin
                        n_cur = NIL;
                    end
                end else if (!r_out_valid || i_out_ready) begin
                    if (r_nres != '0) begin
                        n_out_valid = 1'b1;
                        out_load = 1'b1;
                    end
                    n_out = '0;
                    n_out.status = ttq_pkg::ST_FIRED;
                    n_out.slot = 4'(r_cur[SW-1:0]);
                    n_out.fired_tag = tag_rd;
                    n_out.fired_argument = arg_rd;
                    n_out.due_time = due_rd;
                    n_slot = r_cur[SW-1:0];
                    n_fired[r_cur[SW-1:0]] = 1'b1;
                    n_nres = r_nres + 5'd1;
                    n_head = lnk_rd;
                    n_count = r_count - LW'(1);
                    n_ret_tick = 1'b1;
                    if (per_rd != '0) begin
                        n_per = per_rd;
                        div_req.start = 1'b1;
                        div_req.dividend = due_rd;
                        div_req.divisor = per_rd;
                        n_state = ttq_pkg::S_TICK_DIV;
                    end else begin
                        n_used[r_cur[SW-1:0]] = 1'b0;
                        n_state = ttq_pkg::S_TICK_NEXT;
                    end
                end
            end
            ttq_pkg::S_TICK_DIV: begin
                if (div_rsp.done) begin
                    n_due = prod;
                    n_state = ttq_pkg::S_INS_START;
                end
            end
            ttq_pkg::S_TICK_NEXT: begin
                n_cur = r_head;
                n_state = ttq_pkg::S_TICK_RD;
            end
            ttq_pkg::S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    out_load = 1'b1;
                    n_ret_tick = 1'b0;
                    n_state = ttq_pkg::S_IDLE;
                end
            end
            default: n_state = ttq_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ttq_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_now <= '0; r_head <= NIL; r_count <= '0; r_used <= '0;
            r_out_valid <= 1'b0; r_min_delay <= 16'd2; r_lookahead <= 8'd2;
            r_ret_tick <= 1'b0; r_nres <= '0; r_fired <= '0;
        end else begin
            r_now <= n_now; r_head <= n_head; r_count <= n_count; r_used <= n_used;
            r_out_valid <= n_out_valid; r_ret_tick <= n_ret_tick;
            r_nres <= n_nres; r_fired <= n_fired;
            if (i_cfg_valid) begin
                if (ttq_pkg::t_cfg_idx'(i_cfg_index) == ttq_pkg::CFG_MIN_DELAY) begin
                    r_min_delay <= i_cfg_data;
                end else begin
                    r_lookahead <= i_cfg_data[7:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_item;
        end
        r_due <= n_due; r_per <= n_per; r_prev <= n_prev; r_cur <= n_cur;
        r_slot <= n_slot;
        r_out <= n_out;
        if (out_load) begin
            r_obuf <= r_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_obuf;
    assign o_cfg_ready = 1'b1;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= LW'(SLOT_COUNT)) else $error("task count overflow");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ttq_pkg::S_OUT) |-> !div_rsp.busy) else $error("divider busy at output");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) && o_out_item.last |-> r_state == ttq_pkg::S_IDLE)
        else $error("final item before idle");
endmodule
`default_nettype wire

@@ sim/tb_timed_task_queue.sv @@
module tb_timed_task_queue;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS = 16;
    localparam int NIL = SLOTS;
    localparam longint CYCLE_LIMIT = 3000000;

    class task_queue_scoreboard;
        bit [31:0]  now_ticks;
        bit [31:0]  due_at [SLOTS];
        bit [31:0]  period [SLOTS];
        bit [15:0]  tag [SLOTS];
        bit [15:0]  arg [SLOTS];
        bit         used [SLOTS];
        bit [4:0]   next [SLOTS];
        bit [4:0]   head;
        bit [4:0]   listed;
        bit [15:0]  min_delay;
        bit [7:0]   lookahead;
        ttq_pkg::t_out_item pending_results [$];
        int         errors;

        function new();
            now_ticks = 0;
            head = 5'(NIL);
            listed = 0;
            min_delay = 2;
            lookahead = 2;
            errors = 0;
            foreach (used[i]) begin
                used[i] = 0;
                next[i] = 5'(NIL);
                due_at[i] = 0;
                period[i] = 0;
                tag[i] = 0;
                arg[i] = 0;
            end
        endfunction

        function void set_register(ttq_pkg::t_cfg_idx idx, bit [15:0] data);
            if (idx == ttq_pkg::CFG_MIN_DELAY) min_delay = data;
            else lookahead = data[7:0];
        endfunction

        function void link_in(int s);
            int p;
            int g;
            if (head >= NIL || due_at[s] <= due_at[head]) begin
                next[s] = head;
                head = 5'(s);
            end else begin
                p = int'(head);
                g = 0;
                while (next[p] < NIL && g < SLOTS && due_at[s] > due_at[next[p]]) begin
                    p = int'(next[p]);
                    g++;
                end
                next[s] = next[p];
                next[p] = 5'(s);
            end
            listed++;
        endfunction

        function bit link_out(int s);
            int p;
            int g;
            g = 0;
            if (head >= NIL) return 0;
            if (head == s) begin
                head = next[s];
                return 1;
            end
            p = int'(head);
            while (next[p] < NIL && next[p] != s && g < SLOTS) begin
                p = int'(next[p]);
                g++;
            end
            if (next[p] == s) begin
                next[p] = next[s];
                return 1;
            end
            return 0;
        endfunction

        function void push(ttq_pkg::t_status st, int sl, bit [15:0] tg, bit [15:0] ag,
                           bit [31:0] due);
            ttq_pkg::t_out_item r;
            r.status = st;
            r.slot = sl[3:0];
            r.fired_tag = tg;
            r.fired_argument = ag;
            r.due_time = due;
            r.last = 0;
            pending_results.push_back(r);
        endfunction

        function void note_item(ttq_pkg::t_in_item it);
            bit        fired [SLOTS];
            bit [31:0] window;
            bit [31:0] d;
            int        n;
            int        s;
            n = 0;
            s = NIL;
            foreach (fired[i]) fired[i] = 0;
            case (ttq_pkg::t_mode'(it.mode))
                ttq_pkg::MODE_TICK: begin
                    now_ticks = now_ticks + 1;
                    window = now_ticks + 32'(lookahead);
                    while (n < ttq_pkg::MAX_RESULTS && head < NIL && !fired[head] &&
                           due_at[head] <= window) begin
                        s = int'(head);
                        head = next[s];
                        listed--;
                        push(ttq_pkg::ST_FIRED, s, tag[s], arg[s], due_at[s]);
                        n++;
                        fired[s] = 1;
                        if (period[s] > 0) begin
                            due_at[s] = (due_at[s] / period[s] + 1) * period[s];
                            link_in(s);
                        end else begin
                            used[s] = 0;
                        end
                    end
                    if (n == 0) push(ttq_pkg::ST_NONE, 0, 0, 0, now_ticks);
                end
                ttq_pkg::MODE_ONESHOT, ttq_pkg::MODE_PERIODIC: begin
                    d = (it.delay_ticks < min_delay) ? 32'(min_delay) : it.delay_ticks;
                    if (listed < SLOTS)
                        for (int i = SLOTS - 1; i >= 0; i--) if (!used[i]) s = i;
                    if (s >= NIL) begin
                        push(ttq_pkg::ST_FULL, 0, 0, 0, 0);
                    end else begin
                        if (it.mode == ttq_pkg::MODE_ONESHOT) begin
                            due_at[s] = now_ticks + d;
                            period[s] = 0;
                        end else begin
                            if (d == 0) d = 1;
                            due_at[s] = (now_ticks / d + 1) * d;
                            period[s] = d;
                        end
                        tag[s] = it.task_tag;
                        arg[s] = it.task_argument;
                        used[s] = 1;
                        link_in(s);
                        push(ttq_pkg::ST_SCHEDULED, s, 0, 0, due_at[s]);
                    end
                end
                default: begin
                    s = int'(it.slot_handle);
                    if (s >= SLOTS) begin
                        push(ttq_pkg::ST_BAD, s, 0, 0, 0);
                    end else if (!used[s]) begin
                        push(ttq_pkg::ST_UNLISTED, s, 0, 0, 0);
                    end else begin
                        if (link_out(s)) listed--;
                        used[s] = 0;
                        next[s] = 5'(NIL);
                        push(ttq_pkg::ST_REMOVED, s, 0, 0, due_at[s]);
                    end
                end
            endcase
            pending_results[$].last = 1;
        endfunction

        function void check_result(ttq_pkg::t_out_item got);
            ttq_pkg::t_out_item exp;
            if (pending_results.size() == 0) begin
                $error("unexpected result status=%0d slot=%0d", got.status, got.slot);
                errors++;
                return;
            end
            exp = pending_results.pop_front();
            if (got.status !== exp.status) begin
                $error("status: expected %0d, got %0d", exp.status, got.status);
                errors++;
            end
            if (got.slot !== exp.slot) begin
                $error("slot: expected %0d, got %0d", exp.slot, got.slot);
                errors++;
            end
            if (got.fired_tag !== exp.fired_tag) begin
                $error("fired_tag: expected %0h, got %0h", exp.fired_tag, got.fired_tag);
                errors++;
            end
            if (got.fired_argument !== exp.fired_argument) begin
                $error("fired_argument: expected %0h, got %0h",
                       exp.fired_argument, got.fired_argument);
                errors++;
            end
            if (got.due_time !== exp.due_time) begin
                $error("due_time: expected %0h, got %0h", exp.due_time, got.due_time);
                errors++;
            end
            if (got.last !== exp.last) begin
                $error("last: expected %0b, got %0b", exp.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_ready;
    ttq_pkg::t_in_item  i_in_item;
    logic       o_out_valid;
    logic       i_out_ready;
    ttq_pkg::t_out_item o_out_item;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic       i_cfg_index;
    logic [15:0] i_cfg_data;

    task_queue_scoreboard sb;
    int     in_idle_pct;
    int     out_idle_pct;
    bit     hold_req;
    int     hold_left;
    longint cycles;

    timed_task_queue dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 0;
        i_rst_n = 0;
        i_in_valid = 0;
        i_in_item = '0;
        i_out_ready = 0;
        i_cfg_valid = 0;
        i_cfg_index = 0;
        i_cfg_data = 0;
        hold_req = 0;
        hold_left = 0;
        in_idle_pct = 29;
        out_idle_pct = 29;
        cycles = 0;
        sb = new();
    end

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (hold_req) begin
            hold_left = 400;
            hold_req = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= out_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready) sb.note_item(i_in_item);
        if (i_rst_n && o_out_valid && i_out_ready) sb.check_result(o_out_item);
    end

    task automatic send_item(ttq_pkg::t_mode m, bit [31:0] d, bit [15:0] tg,
                             bit [15:0] ag, bit [3:0] h);
        ttq_pkg::t_in_item it;
        it.mode = m;
        it.delay_ticks = d;
        it.task_tag = tg;
        it.task_argument = ag;
        it.slot_handle = h;
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 0;
            @(posedge i_clk);
        end
        i_in_valid <= 1;
        i_in_item <= it;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    task automatic drain();
        i_in_valid <= 0;
        @(posedge i_clk);
        while (sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic write_register(ttq_pkg::t_cfg_idx idx, bit [15:0] data);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.set_register(idx, data);
        i_cfg_valid <= 0;
        @(posedge i_clk);
    endtask

    task automatic send_random();
        ttq_pkg::t_mode m;
        bit [31:0] d;
        bit [3:0]  h;
        int        r;
        int        pick;
        r = $urandom_range(99);
        m = r < 35 ? ttq_pkg::MODE_TICK : r < 60 ? ttq_pkg::MODE_ONESHOT
          : r < 80 ? ttq_pkg::MODE_PERIODIC : ttq_pkg::MODE_REMOVE;
        case ($urandom_range(9))
            6: d = $urandom;
            7: d = 0;
            8: d = 32'hFFFF_FFFF - $urandom_range(3);
            9: d = $urandom_range(300);
            default: d = $urandom_range(40);
        endcase
        h = 4'($urandom_range(15));
        if ($urandom_range(99) < 70) begin
            pick = $urandom_range(15);
            for (int i = 0; i < SLOTS; i++)
                if (sb.used[(pick + i) % SLOTS]) begin
                    h = 4'((pick + i) % SLOTS);
                    break;
                end
        end
        send_item(m, d, 16'($urandom), 16'($urandom), h);
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        write_register(ttq_pkg::CFG_MIN_DELAY, 16'd0);
        write_register(ttq_pkg::CFG_LOOKAHEAD, 16'd0);
        send_item(ttq_pkg::MODE_PERIODIC, 0, 16'h0001, 16'h0002, 0);
        send_item(ttq_pkg::MODE_ONESHOT, 0, 16'h0003, 16'h0004, 0);
        send_item(ttq_pkg::MODE_TICK, 0, 0, 0, 0);
        send_item(ttq_pkg::MODE_REMOVE, 0, 0, 0, 4'd5);
        send_item(ttq_pkg::MODE_REMOVE, 0, 0, 0, 0);
        send_item(ttq_pkg::MODE_ONESHOT, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 4'hF);
        for (int i = 0; i < 15; i++)
            send_item(ttq_pkg::MODE_ONESHOT, 3, 16'(16'h1000 + i), 16'(16'h2000 + i), 0);
        send_item(ttq_pkg::MODE_ONESHOT, 1, 16'h5555, 16'hAAAA, 0);
        send_item(ttq_pkg::MODE_PERIODIC, 1, 16'hAAAA, 16'h5555, 0);
        repeat (3) send_item(ttq_pkg::MODE_TICK, 0, 0, 0, 0);
        send_item(ttq_pkg::MODE_REMOVE, 0, 0, 0, 0);
        drain();

        write_register(ttq_pkg::CFG_MIN_DELAY, 16'hFFFF);
        write_register(ttq_pkg::CFG_LOOKAHEAD, 16'h00FF);
        repeat (40) send_random();
        drain();

        write_register(ttq_pkg::CFG_MIN_DELAY, 16'd0);
        write_register(ttq_pkg::CFG_LOOKAHEAD, 16'h00FF);
        for (int i = 0; i < 16; i++)
            send_item(ttq_pkg::MODE_PERIODIC, 1, 16'($urandom), 16'($urandom), 0);
        repeat (3) send_item(ttq_pkg::MODE_TICK, 0, 0, 0, 0);
        for (int i = 0; i < 16; i++) send_item(ttq_pkg::MODE_REMOVE, 0, 0, 0, 4'(i));
        drain();

        write_register(ttq_pkg::CFG_MIN_DELAY, 16'd3);
        write_register(ttq_pkg::CFG_LOOKAHEAD, 16'd10);
        hold_req = 1;
        repeat (70) send_random();
        drain();

        write_register(ttq_pkg::CFG_MIN_DELAY, 16'd1);
        write_register(ttq_pkg::CFG_LOOKAHEAD, 16'd1);
        in_idle_pct = 0;
        out_idle_pct = 0;
        repeat (50) send_random();
        in_idle_pct = 29;
        out_idle_pct = 29;
        repeat (40) send_random();
        drain();

        if (sb.errors == 0 && sb.pending_results.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
